// ===== rtl/core/percent_decoder_utf8_check_unit_macros.svh =====
// Assertion helpers used by the top-level RTL unit.
`ifndef PERCENT_DECODER_UTF8_CHECK_UNIT_MACROS_SVH
`define PERCENT_DECODER_UTF8_CHECK_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define PDU8_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define PDU8_NEVER(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(prop)) \
      else $error("forbidden condition seen");
`else
`define PDU8_ASSERT(lbl, clk, rst, prop)
`define PDU8_NEVER(lbl, clk, rst, prop)
`endif

`endif

// ===== rtl/core/pdu8_pkg.sv =====
`default_nettype none

package pdu8_pkg;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_ESCAPE = 2'd1;
   localparam logic [1:0] ST_UTF8   = 2'd2;

   localparam int unsigned RES_OFFSET_WIDTH = 32;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]                  out_byte;
      logic                        byte_valid;
      logic                        done_res;
      logic [1:0]                  status;
      logic [RES_OFFSET_WIDTH-1:0] error_offset;
   } rsp_payload_type;

   typedef struct packed {
      logic                        emit;
      logic [7:0]                  dec_byte;
      logic                        err;
      logic [RES_OFFSET_WIDTH-1:0] err_offset;
   } esc_result_type;

   typedef struct packed {
      logic                        bad;
      logic [RES_OFFSET_WIDTH-1:0] err_offset;
   } utf8_result_type;

endpackage

`default_nettype wire

// ===== rtl/core/pdu8_escape_decoder.sv =====
`default_nettype none

module pdu8_escape_decoder
   import pdu8_pkg::*;
#(
   parameter int OFFSET_WIDTH = 32
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           step,
   input  wire logic [7:0]     in_byte,
   input  wire logic           in_last,
   output esc_result_type      result
);

   localparam logic [1:0] ESC_IDLE = 2'd0;
   localparam logic [1:0] ESC_HIGH = 2'd1;
   localparam logic [1:0] ESC_LOW  = 2'd2;
   localparam logic [7:0] CHAR_PERCENT = 8'h25;

   logic [1:0]              phase_ff, phase_in;
   logic [3:0]              nibble_ff, nibble_in;
   logic [OFFSET_WIDTH-1:0] start_ff, start_in;
   logic [OFFSET_WIDTH-1:0] count_ff, count_in;
   logic                    err_ff, err_in;
   logic [OFFSET_WIDTH-1:0] err_off_ff, err_off_in;
   logic                    hex_ok;
   logic [3:0]              hex_val;
   logic                    emit;
   logic [7:0]              dec_byte;
   logic                    err_final;
   logic [OFFSET_WIDTH-1:0] off_final;

   // {valid, value}
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

   assign {hex_ok, hex_val} = hex_decode(in_byte);

   always_comb begin
      phase_in   = phase_ff;
      nibble_in  = nibble_ff;
      start_in   = start_ff;
      err_in     = err_ff;
      err_off_in = err_off_ff;
      emit       = 1'b0;
      dec_byte   = 8'd0;
      count_in   = (count_ff == '1) ? count_ff : count_ff + 1'b1;
      if (!err_ff) begin
         unique case (phase_ff)
            ESC_IDLE: begin
               if (in_byte == CHAR_PERCENT) begin
                  phase_in = ESC_HIGH;
                  start_in = count_ff;
               end else begin
                  emit     = 1'b1;
                  dec_byte = in_byte;
               end
            end
            ESC_HIGH: begin
               if (!hex_ok) begin
                  err_in     = 1'b1;
                  err_off_in = start_ff;
                  phase_in   = ESC_IDLE;
               end else begin
                  nibble_in = hex_val;
                  phase_in  = ESC_LOW;
               end
            end
            ESC_LOW: begin
               if (!hex_ok) begin
                  err_in     = 1'b1;
                  err_off_in = start_ff;
               end else begin
                  emit     = 1'b1;
                  dec_byte = {nibble_ff, hex_val};
               end
               phase_in = ESC_IDLE;
            end
            default: begin
               phase_in = ESC_IDLE;
            end
         endcase
      end
      // an escape left open by the end of the stream counts as malformed
      err_final = err_in || (phase_in != ESC_IDLE);
      off_final = err_in ? err_off_in : start_in;
   end

   always_comb begin
      result.emit       = emit;
      result.dec_byte   = dec_byte;
      result.err        = in_last && err_final;
      result.err_offset = (in_last && err_final) ? RES_OFFSET_WIDTH'(off_final)
                                                 : '0;
   end

   always_ff @(posedge clock) begin
      if (reset || (step && in_last)) begin
         phase_ff   <= ESC_IDLE;
         nibble_ff  <= '0;
         start_ff   <= '0;
         count_ff   <= '0;
         err_ff     <= 1'b0;
         err_off_ff <= '0;
      end else if (step) begin
         phase_ff   <= phase_in;
         nibble_ff  <= nibble_in;
         start_ff   <= start_in;
         count_ff   <= count_in;
         err_ff     <= err_in;
         err_off_ff <= err_off_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/pdu8_utf8_checker.sv =====
`default_nettype none

module pdu8_utf8_checker
   import pdu8_pkg::*;
#(
   parameter int OFFSET_WIDTH = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        step,
   input  wire logic        emit,
   input  wire logic        check_en,
   input  wire logic [7:0]  dec_byte,
   input  wire logic        in_last,
   output utf8_result_type  result
);

   localparam logic [1:0] UTF_OK      = 2'd0;
   localparam logic [1:0] UTF_PENDING = 2'd1;
   localparam logic [1:0] UTF_FINAL   = 2'd2;
   localparam logic [7:0] CONT_LO     = 8'h80;
   localparam logic [7:0] CONT_HI     = 8'hBF;

   logic [OFFSET_WIDTH-1:0] dcount_ff, dcount_in;
   logic [1:0]              cont_ff, cont_in;
   logic [7:0]              lo_ff, lo_in;
   logic [7:0]              hi_ff, hi_in;
   logic [OFFSET_WIDTH-1:0] lead_ff, lead_in;
   logic [1:0]              state_ff, state_in;
   logic [OFFSET_WIDTH-1:0] err_off_ff, err_off_in;

   always_comb begin
      cont_in    = cont_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      lead_in    = lead_ff;
      state_in   = state_ff;
      err_off_in = err_off_ff;
      dcount_in  = dcount_ff;
      if (emit) begin
         dcount_in = (dcount_ff == '1) ? dcount_ff : dcount_ff + 1'b1;
      end
      if (emit && check_en) begin
         unique case (state_ff)
            UTF_FINAL: begin
            end
            UTF_PENDING: begin
               // bad continuation seen: run out the sequence before settling
               if (cont_ff != 2'd0) begin
                  cont_in = cont_ff - 2'd1;
               end
               if (cont_in == 2'd0) begin
                  state_in = UTF_FINAL;
               end
            end
            UTF_OK: begin
               if (cont_ff != 2'd0) begin
                  if (dec_byte < lo_ff || dec_byte > hi_ff) begin
                     state_in   = UTF_PENDING;
                     err_off_in = dcount_ff;
                  end
                  lo_in   = CONT_LO;
                  hi_in   = CONT_HI;
                  cont_in = cont_ff - 2'd1;
                  if (state_in == UTF_PENDING && cont_in == 2'd0) begin
                     state_in = UTF_FINAL;
                  end
               end else if (dec_byte >= 8'h80) begin
                  lo_in = CONT_LO;
                  hi_in = CONT_HI;
                  if (dec_byte >= 8'hC2 && dec_byte <= 8'hDF) begin
                     cont_in = 2'd1;
                     lead_in = dcount_ff;
                  end else if (dec_byte >= 8'hE0 && dec_byte <= 8'hEF) begin
                     cont_in = 2'd2;
                     lead_in = dcount_ff;
                     if (dec_byte == 8'hE0) lo_in = 8'hA0;
                     if (dec_byte == 8'hED) hi_in = 8'h9F;
                  end else if (dec_byte >= 8'hF0 && dec_byte <= 8'hF4) begin
                     cont_in = 2'd3;
                     lead_in = dcount_ff;
                     if (dec_byte == 8'hF0) lo_in = 8'h90;
                     if (dec_byte == 8'hF4) hi_in = 8'h8F;
                  end else begin
                     state_in   = UTF_FINAL;
                     err_off_in = dcount_ff;
                  end
               end
            end
            default: begin
               state_in = UTF_FINAL;
            end
         endcase
      end
   end

   always_comb begin
      result.bad        = (state_in != UTF_OK) || (cont_in != 2'd0);
      result.err_offset = (state_in == UTF_FINAL) ? RES_OFFSET_WIDTH'(err_off_in)
                                                  : RES_OFFSET_WIDTH'(lead_in);
   end

   always_ff @(posedge clock) begin
      if (reset || (step && in_last)) begin
         dcount_ff  <= '0;
         cont_ff    <= 2'd0;
         lo_ff      <= CONT_LO;
         hi_ff      <= CONT_HI;
         lead_ff    <= '0;
         state_ff   <= UTF_OK;
         err_off_ff <= '0;
      end else if (step) begin
         dcount_ff  <= dcount_in;
         cont_ff    <= cont_in;
         lo_ff      <= lo_in;
         hi_ff      <= hi_in;
         lead_ff    <= lead_in;
         state_ff   <= state_in;
         err_off_ff <= err_off_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/percent_decoder_utf8_check_unit.sv =====
// Items pass an input and an output register; a full output that is not taken
// stalls both. Else one item per cycle; escape/UTF-8 state updates once per item.
// Items that neither decode a byte nor end the stream give no result.
// Reset (synchronous, active high): both stages empty, stream state cleared,
// check_utf8 set to 1.
`default_nettype none
`include "percent_decoder_utf8_check_unit_macros.svh"

module percent_decoder_utf8_check_unit
   import pdu8_pkg::*;
#(
   parameter int OFFSET_WIDTH = 32
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire req_payload_type req_payload,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output rsp_payload_type      rsp_payload,
   input  wire logic            psel,
   input  wire logic            penable,
   input  wire logic            pwrite,
   input  wire logic [2:0]      paddr,
   input  wire logic [31:0]     pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);

   logic            in_valid_ff, in_valid_in;
   req_payload_type in_data_ff;
   logic            out_valid_ff, out_valid_in;
   rsp_payload_type out_data_ff, out_data_in;
   logic            check_ff;
   logic            advance;
   logic            produce;
   esc_result_type  esc;
   utf8_result_type utf;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_payload = out_data_ff;
   assign pready    = 1'b1;
   assign prdata    = (paddr[2] == 1'b0) ? {31'd0, check_ff} : 32'd0;

   pdu8_escape_decoder #(
      .OFFSET_WIDTH(OFFSET_WIDTH)
   ) u_escape (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .in_byte (in_data_ff.in_byte),
      .in_last (in_data_ff.in_last),
      .result  (esc)
   );

   pdu8_utf8_checker #(
      .OFFSET_WIDTH(OFFSET_WIDTH)
   ) u_utf8 (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .emit     (esc.emit),
      .check_en (check_ff),
      .dec_byte (esc.dec_byte),
      .in_last  (in_data_ff.in_last),
      .result   (utf)
   );

   assign produce = esc.emit || in_data_ff.in_last;

   always_comb begin
      out_data_in.out_byte     = esc.emit ? esc.dec_byte : 8'd0;
      out_data_in.byte_valid   = esc.emit;
      out_data_in.done_res     = in_data_ff.in_last;
      out_data_in.status       = ST_OK;
      out_data_in.error_offset = '0;
      if (in_data_ff.in_last) begin
         if (esc.err) begin
            out_data_in.status       = ST_ESCAPE;
            out_data_in.error_offset = esc.err_offset;
         end else if (check_ff && utf.bad) begin
            out_data_in.status       = ST_UTF8;
            out_data_in.error_offset = utf.err_offset;
         end
      end
   end

   always_comb begin
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      if (advance && produce) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         check_ff     <= 1'b1;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
            check_ff <= pwdata[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_payload;
      end
      if (advance && produce) begin
         out_data_ff <= out_data_in;
      end
   end

   `PDU8_ASSERT(a_status_only_at_end, clock, reset, rsp_valid && rsp_payload.status != ST_OK |-> rsp_payload.done_res)
   `PDU8_NEVER(a_empty_result, clock, reset, rsp_valid && !rsp_payload.byte_valid && !rsp_payload.done_res)
   `PDU8_NEVER(a_bad_status_code, clock, reset, rsp_valid && rsp_payload.status == 2'd3)
   `PDU8_ASSERT(a_ok_has_no_offset, clock, reset, rsp_valid && rsp_payload.status == ST_OK |-> rsp_payload.error_offset == '0)

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`default_nettype none

module tb_top;
   import pdu8_pkg::*;

   localparam int          LATENCY        = 2;
   localparam int          LONG_HOLD      = 150;
   localparam int          WATCHDOG_LIMIT = 1000;
   localparam int          REG_CHECK_UTF8 = 0;
   localparam logic [2:0]  CHECK_UTF8_ADDR = 3'(4 * REG_CHECK_UTF8);
   localparam logic [7:0]  PCT            = 8'h25;

   typedef enum logic [1:0] {ESC_IDLE, ESC_HIGH, ESC_LOW} esc_phase_type;
   typedef enum logic [1:0] {U8_CLEAN, U8_PENDING, U8_FAILED} utf8_state_type;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;
   logic            psel = 1'b0;
   logic            penable = 1'b0;
   logic            pwrite = 1'b0;
   logic [2:0]      paddr = '0;
   logic [31:0]     pwdata = '0;
   logic [31:0]     prdata;
   logic            pready;

   percent_decoder_utf8_check_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   always #6 clock = ~clock;

   req_payload_type encoded_q[$];
   rsp_payload_type pending_results[$];
   logic [7:0]      stream_buf[$];
   int              items_queued = 0;
   int              items_taken = 0;
   int              fail_count = 0;
   int              idle_cycles = 0;
   int              req_gap = 0;
   int              req_streak = 0;
   int              rsp_hold = 0;
   int              rsp_streak = 0;
   bit              long_hold_req = 0;
   logic            req_taken = 1'b0;

   // decoder state mirror
   bit              chk_utf8;
   esc_phase_type   esc_phase;
   logic [3:0]      esc_hi;
   logic [31:0]     esc_pos, esc_bad_pos, in_pos, out_pos;
   bit              esc_bad;
   logic [1:0]      cont_left;
   logic [7:0]      cont_lo, cont_hi;
   logic [31:0]     lead_pos, u8_bad_pos;
   utf8_state_type  u8_st;

   function automatic void clear_stream();
      esc_phase = ESC_IDLE;
      esc_hi = '0;
      esc_pos = '0;
      esc_bad_pos = '0;
      in_pos = '0;
      out_pos = '0;
      esc_bad = 0;
      cont_left = '0;
      cont_lo = 8'h80;
      cont_hi = 8'hBF;
      lead_pos = '0;
      u8_st = U8_CLEAN;
      u8_bad_pos = '0;
   endfunction

   function automatic logic [31:0] bump(logic [31:0] v);
      return (v == '1) ? v : v + 32'd1;
   endfunction

   function automatic int hex_digit(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c - "0");
      if (c >= "a" && c <= "f") return int'(c - "a") + 10;
      if (c >= "A" && c <= "F") return int'(c - "A") + 10;
      return -1;
   endfunction

   function automatic void utf8_track(logic [7:0] b, logic [31:0] pos);
      if (u8_st == U8_FAILED) return;
      if (u8_st == U8_PENDING) begin
         if (cont_left != 0) cont_left--;
         if (cont_left == 0) u8_st = U8_FAILED;
         return;
      end
      if (cont_left != 0) begin
         if (b < cont_lo || b > cont_hi) begin
            u8_st = U8_PENDING;
            u8_bad_pos = pos;
         end
         cont_lo = 8'h80;
         cont_hi = 8'hBF;
         cont_left--;
         if (u8_st == U8_PENDING && cont_left == 0) u8_st = U8_FAILED;
         return;
      end
      if (b < 8'h80) return;
      cont_lo = 8'h80;
      cont_hi = 8'hBF;
      if (b >= 8'hC2 && b <= 8'hDF) begin
         cont_left = 2'd1;
      end else if (b >= 8'hE0 && b <= 8'hEF) begin
         cont_left = 2'd2;
         if (b == 8'hE0) cont_lo = 8'hA0;
         if (b == 8'hED) cont_hi = 8'h9F;
      end else if (b >= 8'hF0 && b <= 8'hF4) begin
         cont_left = 2'd3;
         if (b == 8'hF0) cont_lo = 8'h90;
         if (b == 8'hF4) cont_hi = 8'h8F;
      end else begin
         u8_st = U8_FAILED;
         u8_bad_pos = pos;
         return;
      end
      lead_pos = pos;
   endfunction

   function automatic bit decode_item(input req_payload_type it, output rsp_payload_type res);
      logic [7:0]  b;
      logic [7:0]  dec;
      logic [31:0] pos;
      bit          emit;
      int          d;
      b = it.in_byte;
      pos = in_pos;
      emit = 0;
      dec = '0;
      res = '0;
      in_pos = bump(in_pos);
      if (!esc_bad) begin
         if (esc_phase == ESC_IDLE) begin
            if (b == PCT) begin
               esc_phase = ESC_HIGH;
               esc_pos = pos;
            end else begin
               emit = 1;
               dec = b;
            end
         end else begin
            d = hex_digit(b);
            if (d < 0) begin
               esc_bad = 1;
               esc_bad_pos = esc_pos;
               esc_phase = ESC_IDLE;
            end else if (esc_phase == ESC_HIGH) begin
               esc_hi = d[3:0];
               esc_phase = ESC_LOW;
            end else begin
               emit = 1;
               dec = {esc_hi, d[3:0]};
               esc_phase = ESC_IDLE;
            end
         end
      end
      if (emit) begin
         if (chk_utf8) utf8_track(dec, out_pos);
         out_pos = bump(out_pos);
      end
      if (!emit && !it.in_last) return 0;
      res.out_byte = dec;
      res.byte_valid = emit;
      res.done_res = it.in_last;
      res.status = ST_OK;
      res.error_offset = '0;
      if (it.in_last) begin
         if (!esc_bad && esc_phase != ESC_IDLE) begin
            esc_bad = 1;
            esc_bad_pos = esc_pos;
         end
         if (esc_bad) begin
            res.status = ST_ESCAPE;
            res.error_offset = esc_bad_pos;
         end else if (chk_utf8) begin
            if (u8_st == U8_FAILED) begin
               res.status = ST_UTF8;
               res.error_offset = u8_bad_pos;
            end else if (u8_st == U8_PENDING || cont_left != 0) begin
               res.status = ST_UTF8;
               res.error_offset = lead_pos;
            end
         end
         clear_stream();
      end
      return 1;
   endfunction

   task automatic flag_error(string msg);
      fail_count++;
      if (fail_count <= 10) $display("%s", msg);
   endtask

   // stimulus building
   task automatic push_item(logic [7:0] b, bit last);
      req_payload_type it;
      it.in_byte = b;
      it.in_last = last;
      encoded_q.push_back(it);
      items_queued++;
   endtask

   task automatic push_text(string s, bit close);
      for (int i = 0; i < s.len(); i++) push_item(s[i], close && i == s.len() - 1);
   endtask

   function automatic logic [7:0] hex_char(logic [3:0] nib);
      logic [7:0] base;
      if (nib < 10) return 8'h30 + {4'h0, nib};
      base = $urandom_range(0, 1) ? "A" : "a";
      return base + {4'h0, nib} - 8'd10;
   endfunction

   function automatic logic [7:0] non_hex();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255)); while (hex_digit(c) >= 0);
      return c;
   endfunction

   task automatic add_dec(logic [7:0] b);
      if (b == PCT || $urandom_range(0, 99) < 35) begin
         stream_buf.push_back(PCT);
         stream_buf.push_back(hex_char(b[7:4]));
         stream_buf.push_back(hex_char(b[3:0]));
      end else begin
         stream_buf.push_back(b);
      end
   endtask

   task automatic add_cont();
      add_dec(8'($urandom_range(8'h80, 8'hBF)));
   endtask

   task automatic put_char();
      int unsigned c;
      case ($urandom_range(0, 5))
         0, 1, 2: add_dec(8'($urandom_range(0, 127)));
         3: begin
            c = $urandom_range(32'h80, 32'h7FF);
            add_dec(8'hC0 | 8'(c >> 6));
            add_dec(8'h80 | 8'(c & 32'h3F));
         end
         4: begin
            do c = $urandom_range(32'h800, 32'hFFFF); while (c >= 32'hD800 && c <= 32'hDFFF);
            add_dec(8'hE0 | 8'(c >> 12));
            add_dec(8'h80 | 8'((c >> 6) & 32'h3F));
            add_dec(8'h80 | 8'(c & 32'h3F));
         end
         default: begin
            c = $urandom_range(32'h10000, 32'h10FFFF);
            add_dec(8'hF0 | 8'(c >> 18));
            add_dec(8'h80 | 8'((c >> 12) & 32'h3F));
            add_dec(8'h80 | 8'((c >> 6) & 32'h3F));
            add_dec(8'h80 | 8'(c & 32'h3F));
         end
      endcase
   endtask

   // truncated sequences and open escapes only make sense at the end of a stream
   task automatic put_defect(int kind);
      case (kind)
         0: begin
            add_dec(8'($urandom_range(8'hC0, 8'hC1)));
            add_cont();
         end
         1: begin
            add_dec(8'hE0);
            add_dec(8'($urandom_range(8'h80, 8'h9F)));
            add_cont();
         end
         2: begin
            add_dec(8'hF0);
            add_dec(8'($urandom_range(8'h80, 8'h8F)));
            add_cont();
            add_cont();
         end
         3: begin
            add_dec(8'hED);
            add_dec(8'($urandom_range(8'hA0, 8'hBF)));
            add_cont();
         end
         4: begin
            if ($urandom_range(0, 1)) begin
               add_dec(8'hF4);
               add_dec(8'($urandom_range(8'h90, 8'hBF)));
               add_cont();
               add_cont();
            end else begin
               add_dec(8'($urandom_range(8'hF5, 8'hFF)));
            end
         end
         5: add_cont();
         6: begin
            add_dec($urandom_range(0, 1) ? 8'($urandom_range(8'hE1, 8'hEC))
                                         : 8'($urandom_range(8'hF1, 8'hF3)));
            if ($urandom_range(0, 1)) add_cont();
            add_dec($urandom_range(0, 1) ? 8'($urandom_range(0, 8'h7F))
                                         : 8'($urandom_range(8'hC0, 8'hFF)));
            if ($urandom_range(0, 1)) add_cont();
         end
         7: begin
            stream_buf.push_back(PCT);
            if ($urandom_range(0, 1)) stream_buf.push_back(hex_char(4'($urandom_range(0, 15))));
            stream_buf.push_back(non_hex());
         end
         8: begin
            case ($urandom_range(0, 2))
               0: add_dec(8'($urandom_range(8'hC2, 8'hDF)));
               1: begin
                  add_dec(8'($urandom_range(8'hE1, 8'hEC)));
                  if ($urandom_range(0, 1)) add_cont();
               end
               default: begin
                  add_dec(8'($urandom_range(8'hF1, 8'hF3)));
                  repeat ($urandom_range(0, 2)) add_cont();
               end
            endcase
         end
         default: begin
            stream_buf.push_back(PCT);
            if ($urandom_range(0, 1)) stream_buf.push_back(hex_char(4'($urandom_range(0, 15))));
         end
      endcase
   endtask

   task automatic build_stream(bit close);
      int kind;
      int defect;
      stream_buf.delete();
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
         repeat ($urandom_range(1, 8)) put_char();
      end else if (kind < 90) begin
         defect = $urandom_range(0, 9);
         repeat ($urandom_range(0, 3)) put_char();
         put_defect(defect);
         if (defect < 8) repeat ($urandom_range(0, 3)) put_char();
      end else begin
         repeat ($urandom_range(1, 12)) stream_buf.push_back(8'($urandom_range(0, 255)));
      end
      foreach (stream_buf[i]) push_item(stream_buf[i], close && i == stream_buf.size() - 1);
   endtask

   task automatic fill_random(int n, bit leave_open);
      int start;
      start = items_queued;
      while (items_queued - start < n) build_stream(1);
      if (leave_open) build_stream(0);
   endtask

   task automatic csr_access(input bit wr, input logic [2:0] addr, input logic [31:0] wdata,
                             output logic [31:0] rdata);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= wr;
      paddr <= addr;
      pwdata <= wdata;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic set_check(bit v);
      logic [31:0] rd;
      csr_access(1, CHECK_UTF8_ADDR, {31'd0, v}, rd);
      chk_utf8 = v;
      csr_access(0, CHECK_UTF8_ADDR, '0, rd);
      if (rd[0] !== v) flag_error($sformatf("check_utf8 readback: exp %b got %b", v, rd[0]));
   endtask

   task automatic settle();
      while (items_taken != items_queued || pending_results.size() != 0) @(negedge clock);
      repeat (LATENCY + 2) @(negedge clock);
   endtask

   // sender
   always @(negedge clock) begin : req_drive
      int r;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (encoded_q.size() != 0) begin
            req_payload <= encoded_q.pop_front();
            req_valid <= 1'b1;
            if (req_streak > 0) begin
               req_streak--;
            end else begin
               r = $urandom_range(0, 99);
               if (r < 5) req_streak = $urandom_range(20, 60);
               else if (r < 65) req_gap = 0;
               else if (r < 92) req_gap = $urandom_range(1, 3);
               else req_gap = $urandom_range(8, 30);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver
   always @(negedge clock) begin : rsp_drive
      int r;
      if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_ready <= 1'b0;
      end else if (long_hold_req) begin
         long_hold_req = 0;
         rsp_hold = LONG_HOLD - 1;
         rsp_ready <= 1'b0;
      end else if (rsp_streak > 0) begin
         rsp_streak--;
         rsp_ready <= 1'b1;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 5) begin
            rsp_streak = $urandom_range(20, 60);
            rsp_ready <= 1'b1;
         end else if (r < 75) begin
            rsp_ready <= 1'b1;
         end else if (r < 95) begin
            rsp_hold = $urandom_range(0, 3);
            rsp_ready <= 1'b0;
         end else begin
            rsp_hold = $urandom_range(10, 30);
            rsp_ready <= 1'b0;
         end
      end
   end

   // monitor, prediction and watchdog
   always @(posedge clock) begin : rsp_check
      rsp_payload_type want;
      bit              bad;
      if (reset) begin
         req_taken <= 1'b0;
         idle_cycles = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               flag_error($sformatf("unexpected result: byte %h v%b d%b st%0d off%0d",
                  rsp_payload.out_byte, rsp_payload.byte_valid, rsp_payload.done_res,
                  rsp_payload.status, rsp_payload.error_offset));
            end else begin
               want = pending_results.pop_front();
               bad = (rsp_payload.out_byte !== want.out_byte)
                  || (rsp_payload.byte_valid !== want.byte_valid)
                  || (rsp_payload.done_res !== want.done_res)
                  || (rsp_payload.status !== want.status)
                  || (rsp_payload.error_offset !== want.error_offset);
               if (bad) flag_error($sformatf(
                  "mismatch: exp byte %h v%b d%b st%0d off%0d, got byte %h v%b d%b st%0d off%0d",
                  want.out_byte, want.byte_valid, want.done_res, want.status,
                  want.error_offset, rsp_payload.out_byte, rsp_payload.byte_valid,
                  rsp_payload.done_res, rsp_payload.status, rsp_payload.error_offset));
            end
         end
         if (req_valid && req_ready) begin
            items_taken++;
            if (decode_item(req_payload, want)) pending_results.push_back(want);
         end
         req_taken <= req_valid && req_ready;
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable && pready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin : stimulus
      chk_utf8 = 1;
      clear_stream();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      set_check(1);
      push_text("A%4a%FF", 1);          // both hex cases, invalid lead byte
      push_text("%g1x", 1);             // bad escape, rest ignored
      push_text("a%4", 1);              // escape cut short
      push_item(8'hE2, 0);              // cut-short sequence with bad continuation
      push_item(8'h41, 1);
      push_item(8'h00, 1);
      push_text("%C3%a9", 1);
      settle();

      set_check(0);
      fill_random(200, 1);
      settle();

      // flip mid-stream, then starve the output
      set_check(1);
      fill_random(300, 1);
      long_hold_req = 1;
      settle();

      set_check(0);
      fill_random(200, 0);
      settle();

      set_check(1);
      fill_random(230, 0);
      settle();

      if (fail_count == 0 && pending_results.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/pdu8_pkg.sv
rtl/core/pdu8_escape_decoder.sv
rtl/core/pdu8_utf8_checker.sv
rtl/core/percent_decoder_utf8_check_unit.sv
dv/tb_top.sv
